[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/khc_pkg.sv]
package khc_pkg;

    localparam int KMER_LEN    = 6;
    localparam int COUNT_BITS  = 32;
    localparam int INDEX_BITS  = 2 * KMER_LEN;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int FILL_BITS   = $clog2(KMER_LEN + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS    = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Request kind codes
    localparam logic KIND_BASE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [1:0]  base_code;
        logic [11:0] query_index;
    } req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] kmer_count;
        logic [OUT_BITS-1:0] total_count;
    } rsp_t;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_QUERY = 1'b1
    } op_kind_t;

    // Work passed from front to back
    typedef struct packed {
        op_kind_t              kind;
        logic [INDEX_BITS-1:0] index;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } back_state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

[src/khc_queue.sv]
`include "assert_macros.svh"

module khc_queue
    import khc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  op_t     wr_op,
    input  logic    rd_en,
    output op_t     rd_op,
    output q_stat_t stat
);

    op_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    assign rd_op      = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    `ASSERT_ALWAYS(a_no_overflow, !(wr_en && stat.full), "queue written while full")
    `ASSERT_ALWAYS(a_no_underflow, !(rd_en && stat.empty), "queue read while empty")
    `ASSERT_NEXT(a_cnt_grow, wr_en && !rd_en, cnt_reg == $past(cnt_reg) + 1'b1, "count slip")

endmodule

[src/khc_front.sv]
module khc_front
    import khc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  req_t    request,
    output logic    full,
    input  logic    clearing,
    input  q_stat_t q_stat,
    output logic    q_wr_en,
    output op_t     q_wr_op
);

    logic [INDEX_BITS-1:0] window_reg, window_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic                  accept;
    logic                  is_query;

    assign full     = q_stat.full || clearing;
    assign accept   = push && !full;
    assign is_query = (request.kind == KIND_QUERY);

    always_comb
    begin
        window_next = INDEX_BITS'({window_reg, request.base_code});
        fill_next   = (fill_reg < FILL_BITS'(KMER_LEN)) ? fill_reg + 1'b1 : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept && !is_query)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

    // A base only produces work once the window holds a full k-mer
    always_comb
    begin
        q_wr_en = 1'b0;
        q_wr_op.kind  = OP_COUNT;
        q_wr_op.index = window_next;
        if (accept)
        begin
            if (is_query)
            begin
                q_wr_en       = 1'b1;
                q_wr_op.kind  = OP_QUERY;
                q_wr_op.index = INDEX_BITS'(request.query_index);
            end
            else if (fill_next == FILL_BITS'(KMER_LEN))
            begin
                q_wr_en = 1'b1;
            end
        end
    end

endmodule

[src/khc_back.sv]
`include "assert_macros.svh"

module khc_back
    import khc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t q_stat,
    input  op_t     q_rd_op,
    output logic    q_rd_en,
    output logic    clearing,
    input  logic    pop,
    output logic    empty,
    output rsp_t    result
);

    logic [COUNT_BITS-1:0] table_mem [TABLE_DEPTH];

    back_state_t           state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_idx_reg, clr_idx_next;
    op_t                   op_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  res_valid_reg, res_valid_next;
    rsp_t                  res_reg;
    logic                  res_load;
    logic                  slot_free;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    assign clearing  = (state_reg == S_CLEAR);
    assign slot_free = !res_valid_reg || pop;

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        q_rd_en      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = clr_idx_reg;
        mem_wdata    = '0;
        total_next   = total_reg;
        res_load     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == INDEX_BITS'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_stat.empty && (q_rd_op.kind == OP_COUNT || slot_free))
                begin
                    q_rd_en    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg.kind == OP_COUNT)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = op_reg.index;
                    mem_wdata  = sat_inc(rd_data_reg);
                    total_next = sat_inc(total_reg);
                end
                else
                begin
                    res_load = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Table port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (q_rd_en)
        begin
            rd_data_reg <= table_mem[q_rd_op.index];
            op_reg      <= q_rd_op;
        end
        if (res_load)
        begin
            res_reg.kmer_count  <= OUT_BITS'(rd_data_reg);
            res_reg.total_count <= OUT_BITS'(total_reg);
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    `ASSERT_ALWAYS(a_no_work_in_clear, !(clearing && q_rd_en), "work taken during clear")
    `ASSERT_NEXT(a_total_monotonic, 1'b1, total_reg >= $past(total_reg), "total went down")
    `ASSERT_ALWAYS(a_no_result_clobber, !(res_load && res_valid_reg), "result overwritten")

endmodule

[src/kmer_histogram_counter_core.sv]
// A query transaction passes through the work queue and the back end's table read before its
// result is loaded into the result register. The back end handles each counted k-mer or
// query as a table read, then a write or result load, taking no new work until done; a base
// that completes no k-mer is handled by the front alone. Reset: rst_n is asynchronous, active
// low. Afterwards all 4096 table entries are cleared one entry a cycle, while full stays high.
module kmer_histogram_counter_core
    import khc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t request,
    output logic empty,
    input  logic pop,
    output rsp_t result
);

    // Front to back work queue
    q_stat_t q_stat;
    logic    q_wr_en;
    op_t     q_wr_op;
    logic    q_rd_en;
    op_t     q_rd_op;

    // Held high by the back end while the table is being zeroed
    logic    clearing;

    // Front: tracks the sliding window and turns transactions into table work
    khc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .clearing (clearing),
        .q_stat   (q_stat),
        .q_wr_en  (q_wr_en),
        .q_wr_op  (q_wr_op)
    );

    // Short queue so front and back stall independently
    khc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_wr_en),
        .wr_op (q_wr_op),
        .rd_en (q_rd_en),
        .rd_op (q_rd_op),
        .stat  (q_stat)
    );

    // Back: count table read-modify-write, running total and result register
    khc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_rd_op  (q_rd_op),
        .q_rd_en  (q_rd_en),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

[test/kmer_histogram_counter_core_test.sv]
module kmer_histogram_counter_core_test;
    import khc_pkg::*;

    // Base codes as carried in request.base_code
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // The limit covers the table clear after reset, ~700 transactions and the long receiver hold-off.
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int END_SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    req_t request = '0;
    logic full;
    logic empty;
    rsp_t result;

    // Shadow state of the counter, advanced once per accepted transaction
    logic [COUNT_BITS-1:0] shadow_counts [TABLE_DEPTH];
    logic [INDEX_BITS-1:0] shadow_window = '0;
    int                    shadow_fill = 0;
    logic [COUNT_BITS-1:0] shadow_total = '0;
    bit                    kmer_hit [TABLE_DEPTH];
    logic [INDEX_BITS-1:0] seen_kmers [$];

    // Read results still owed by the block, oldest first
    rsp_t expected_counts [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  bases_sent = 0;
    int  reads_sent = 0;
    int  results_checked = 0;
    int  hold_len = 0;     // receiver hold-off request, picked up by the receiver process
    bit  calm = 1'b0;      // no idling on either side when set
    logic [COUNT_BITS-1:0] top_count = '0;

    kmer_histogram_counter_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_counts.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Saturating increment at the counter width
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Apply one accepted transaction to the shadow state. A base shifts into the
    // window (oldest base in the top bits); once KMER_LEN bases have been seen each
    // base counts the k-mer now in the window. A read owes one result.
    task automatic tally_transaction(input req_t r);
        rsp_t want;
        if (r.kind == KIND_BASE)
        begin
            shadow_window = {shadow_window[INDEX_BITS-3:0], r.base_code};
            if (shadow_fill < KMER_LEN)
                shadow_fill++;
            if (shadow_fill >= KMER_LEN)
            begin
                shadow_counts[shadow_window] = bump(shadow_counts[shadow_window]);
                shadow_total = bump(shadow_total);
                if (shadow_counts[shadow_window] > top_count)
                    top_count = shadow_counts[shadow_window];
                if (!kmer_hit[shadow_window])
                begin
                    kmer_hit[shadow_window] = 1'b1;
                    seen_kmers.push_back(shadow_window);
                end
            end
            bases_sent++;
        end
        else
        begin
            want.kmer_count  = shadow_counts[r.query_index[INDEX_BITS-1:0]][OUT_BITS-1:0];
            want.total_count = shadow_total[OUT_BITS-1:0];
            expected_counts.push_back(want);
            reads_sent++;
        end
    endtask

    // Unused fields carry random noise so every request bit toggles
    function automatic req_t base_req(input logic [1:0] b);
        req_t r;
        r.kind        = KIND_BASE;
        r.base_code   = b;
        r.query_index = 12'($urandom());
        return r;
    endfunction

    function automatic req_t read_req(input logic [INDEX_BITS-1:0] idx);
        req_t r;
        r.kind        = KIND_QUERY;
        r.base_code   = 2'($urandom_range(0, 3));
        r.query_index = idx;
        return r;
    endfunction

    // Read targets: mostly the k-mer just counted (exercises read after write) or one
    // already counted, otherwise anywhere in the table.
    function automatic logic [INDEX_BITS-1:0] pick_query();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return shadow_window;
        if (roll < 7 && seen_kmers.size() > 0)
            return seen_kmers[$urandom_range(0, seen_kmers.size() - 1)];
        return INDEX_BITS'($urandom());
    endfunction

    // Offer one transaction. Entered and left at a falling edge; push is left high
    // so back-to-back transactions need no extra cycle.
    task automatic send_item(input req_t r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tally_transaction(r);
        @(negedge clk);
    endtask

    // Receiver: pops freely, with random stalls and the occasional long hold-off
    always
    begin
        @(negedge clk);
        if (hold_len > 0)
        begin
            pop <= 1'b0;
            repeat (hold_len) @(negedge clk);
            hold_len = 0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
        else
            pop <= 1'b1;
    end

    // Result checker: each popped transaction against the oldest owed result
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got count %0d total %0d",
                         $time, result.kmer_count, result.total_count);
                errors++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (result.kmer_count !== want.kmer_count)
                begin
                    $display("%0t: kmer_count mismatch: expected %0d, got %0d",
                             $time, want.kmer_count, result.kmer_count);
                    errors++;
                end
                if (result.total_count !== want.total_count)
                begin
                    $display("%0t: total_count mismatch: expected %0d, got %0d",
                             $time, want.total_count, result.total_count);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // Freshly cleared table: both ends of the index range and alternating bits
    task automatic test_cleared_table();
        send_item(read_req('0));
        send_item(read_req({INDEX_BITS{1'b1}}));
        send_item(read_req(12'hAAA));
        send_item(read_req(12'h555));
    endtask

    // Fewer than KMER_LEN bases count nothing; the sixth counts the first k-mer
    task automatic test_window_fill();
        send_item(base_req(BASE_A));
        send_item(base_req(BASE_C));
        send_item(base_req(BASE_G));
        send_item(base_req(BASE_T));
        send_item(base_req(BASE_A));
        send_item(read_req(shadow_window));
        send_item(base_req(BASE_C));
        send_item(read_req(shadow_window));
    endtask

    // Homopolymer run: the same k-mer counted on consecutive transactions, read
    // straight after the last increment
    task automatic test_repeated_kmer();
        repeat (7) send_item(base_req(BASE_T));
        send_item(read_req({INDEX_BITS{1'b1}}));
        send_item(read_req('0));
    endtask

    // Receiver holds off for a long stretch while reads keep coming, so the result register
    // stays taken, the work queue fills and full stalls the sender
    task automatic test_backpressure();
        hold_len = HOLD_OFF_CYCLES;
        repeat (30)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(base_req(2'($urandom_range(0, 3))));
            else
                send_item(read_req(pick_query()));
        end
    endtask

    // Bases mostly from short repeating motifs so k-mers recur and counts climb,
    // with random bases mixed in; about a third of transactions are reads
    task automatic test_random_stream(input int n_items);
        logic [1:0] motif [8];
        int         motif_len;
        int         pos;
        logic [1:0] b;
        motif_len = 1;
        pos = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 24 == 0)
            begin
                motif_len = $urandom_range(1, 8);
                foreach (motif[k])
                    motif[k] = 2'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 2) == 0)
                send_item(read_req(pick_query()));
            else
            begin
                if ($urandom_range(0, 9) < 8)
                    b = motif[pos % motif_len];
                else
                    b = 2'($urandom_range(0, 3));
                pos++;
                send_item(base_req(b));
            end
        end
    endtask

    // Last part: no idling either side, full-rate transactions
    task automatic test_steady_stream();
        calm = 1'b1;
        test_random_stream(100);
    endtask

    initial
    begin
        foreach (shadow_counts[i])
        begin
            shadow_counts[i] = '0;
            kmer_hit[i] = 1'b0;
        end

        // Reset once; the block then clears its table with full held high
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_table();
        test_window_fill();
        test_repeated_kmer();
        test_backpressure();
        test_random_stream(480);
        test_steady_stream();

        push <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d bases and %0d count reads (%0d results checked).",
                 bases_sent, reads_sent, results_checked);
        $display("%0d distinct k-mers counted, highest single count %0d, total %0d.",
                 seen_kmers.size(), top_count, shadow_total);
        if (errors == 0 && expected_counts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
